// File: rtl/core/task_pool_rebalancer_core_macros.svh
// Assertion macros shared by the task pool rebalancer RTL.
// Included by modules that carry concurrent assertions.
`ifndef TASK_POOL_REBALANCER_CORE_MACROS_SVH
`define TASK_POOL_REBALANCER_CORE_MACROS_SVH
// Property that must hold on every clock edge outside reset.
`define TPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication that must hold on every clock edge outside reset.
`define TPR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

// File: rtl/core/tpr_pkg.sv
// Package for the task pool rebalancer: sizes, payload structs, request codes.
// No dependencies.
`timescale 1ns / 1ps
package tpr_pkg;
    localparam int MaxProcs    = 8;
    localparam int BucketDepth = 32;
    localparam int RankW       = $clog2(MaxProcs);
    localparam int SlotW       = $clog2(BucketDepth);
    localparam int CntW        = $clog2(BucketDepth + 1);
    localparam int AddrW       = RankW + SlotW;
    localparam int SumW        = CntW + RankW;
    localparam int GainCap     = 32;
    localparam int GainW       = $clog2(GainCap + 1);

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_REBAL = 2'd2;

    localparam logic [0:0] KIND_GAIN = 1'b0;
    localparam logic [0:0] KIND_SUM  = 1'b1;

    localparam logic [0:0] REG_NUM_PROCS = 1'b0;
    localparam logic [0:0] REG_OWN_RANK  = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [2:0]         bucket_index;
        logic signed [15:0] task_a;
        logic signed [15:0] task_b;
        logic [5:0]         count_0;
        logic [5:0]         count_1;
        logic [5:0]         count_2;
        logic [5:0]         count_3;
        logic [5:0]         count_4;
        logic [5:0]         count_5;
        logic [5:0]         count_6;
        logic [5:0]         count_7;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] gained_a;
        logic signed [15:0] gained_b;
        logic [5:0]         lost_count;
        logic               pool_empty;
        logic               overflow;
        logic               last;
    } out_item_t;
endpackage

// File: rtl/core/tpr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tpr_ram #(
    parameter int Width = 32,
    parameter int Depth = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/core/task_pool_rebalancer_core.sv
// Task pool rebalancer top level: sequencer, list pointers and task RAM.
// Depends on tpr_pkg, tpr_ram and task_pool_rebalancer_core_macros.svh.
// Load and clear items may follow back to back. A rebalance trims each list, sorts,
// steps the pointers, moves each task through read, wait and move steps with an emit
// step per reported gain, and ends with a summary; output stalls lengthen it, and
// input stalls until then. Reset clears pointers, counts and flags, not the RAM.
`timescale 1ns / 1ps
`include "task_pool_rebalancer_core_macros.svh"
module task_pool_rebalancer_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  tpr_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output tpr_pkg::out_item_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import tpr_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_TRIM  = 10'b0000000010,
        ST_SORT  = 10'b0000000100,
        ST_LO    = 10'b0000001000,
        ST_HI    = 10'b0000010000,
        ST_READ  = 10'b0000100000,
        ST_WAIT  = 10'b0001000000,
        ST_MOVE  = 10'b0010000000,
        ST_EMIT  = 10'b0100000000,
        ST_SUMM  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]       num_procs_reg;
    logic [RankW-1:0] own_rank_reg;
    logic [SlotW-1:0] front_reg [MaxProcs];
    logic [CntW-1:0]  total_reg [MaxProcs];
    logic [RankW-1:0] order_reg [MaxProcs];
    logic             overflow_reg;
    in_item_t         item_reg;
    logic [RankW:0]   idx_reg;
    logic [RankW:0]   lo_reg, hi_reg;
    logic [SumW-1:0]  sum_reg, raw_sum_reg;
    logic [CntW-1:0]  lost_reg;
    logic [GainW-1:0] gains_reg;
    logic             moved_reg;
    logic             sorted_reg;
    logic             out_valid_reg;
    out_item_t        out_reg;

    // Effective worker count.
    logic [RankW:0] n_eff;
    always_comb
    begin
        if (num_procs_reg == 4'd0)
            n_eff = (RankW+1)'(1);
        else if ({1'b0, num_procs_reg} > 5'(MaxProcs))
            n_eff = (RankW+1)'(MaxProcs);
        else
            n_eff = (RankW+1)'(num_procs_reg);
    end

    // Per-rank reported count.
    function automatic logic [5:0] count_of(input in_item_t it, input logic [RankW-1:0] r);
        logic [5:0] c;
        c = 6'd0;
        unique case (r)
            3'd0: c = it.count_0;
            3'd1: c = it.count_1;
            3'd2: c = it.count_2;
            3'd3: c = it.count_3;
            3'd4: c = it.count_4;
            3'd5: c = it.count_5;
            3'd6: c = it.count_6;
            3'd7: c = it.count_7;
            default: c = 6'd0;
        endcase
        return c;
    endfunction

    // Share threshold at a sorted position; sum / n via a constant table of
    // divisors, since n is at most eight and the sum at most 256.
    logic [SumW-1:0] quot;
    logic [RankW:0]  remd;
    always_comb
    begin
        quot = '0;
        remd = '0;
        unique case (n_eff)
            4'd1: begin quot = sum_reg;        remd = '0; end
            4'd2: begin quot = sum_reg >> 1;   remd = (RankW+1)'(sum_reg[0]); end
            4'd4: begin quot = sum_reg >> 2;   remd = (RankW+1)'(sum_reg[1:0]); end
            4'd8: begin quot = sum_reg >> 3;   remd = (RankW+1)'(sum_reg[2:0]); end
            4'd3: begin quot = SumW'((18'(sum_reg) * 18'd171) >> 9);
                        remd = (RankW+1)'(sum_reg - quot * 2'd3); end
            4'd5: begin quot = SumW'((18'(sum_reg) * 18'd205) >> 10);
                        remd = (RankW+1)'(sum_reg - quot * 3'd5); end
            4'd6: begin quot = SumW'((18'(sum_reg) * 18'd171) >> 10);
                        remd = (RankW+1)'(sum_reg - quot * 3'd6); end
            4'd7: begin quot = SumW'((18'(sum_reg) * 18'd293) >> 11);
                        remd = (RankW+1)'(sum_reg - quot * 3'd7); end
            default: begin quot = sum_reg; remd = '0; end
        endcase
    end

    function automatic logic [SumW-1:0] share(input logic [SumW-1:0] q, input logic [RankW:0] rm,
                                              input logic [RankW:0] n, input logic [RankW:0] p);
        return q + SumW'(((n - p) <= rm) ? 1 : 0);
    endfunction

    logic [RankW-1:0] lo_w, hi_w;
    assign lo_w = order_reg[lo_reg[RankW-1:0]];
    assign hi_w = order_reg[hi_reg[RankW-1:0]];

    logic [SumW-1:0] lo_share, hi_share;
    assign lo_share = share(quot, remd, n_eff, lo_reg);
    assign hi_share = share(quot, remd, n_eff, hi_reg);

    // Task RAM.
    logic             ram_we;
    logic [AddrW-1:0] ram_waddr, ram_raddr;
    logic [31:0]      ram_wdata, ram_rdata;

    tpr_ram #(.Width(32), .Depth(MaxProcs * BucketDepth)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [SlotW-1:0] load_slot, hi_slot, lo_slot;
    logic [RankW-1:0] ld_rank;
    assign ld_rank   = in_data.bucket_index;
    assign load_slot = front_reg[ld_rank] + SlotW'(total_reg[ld_rank]);
    assign hi_slot   = front_reg[hi_w] + SlotW'(total_reg[hi_w] - 1'b1);
    assign lo_slot   = front_reg[lo_w] + SlotW'(total_reg[lo_w]);

    logic load_ok;
    assign load_ok = ({1'b0, ld_rank} < n_eff) && (total_reg[ld_rank] < CntW'(BucketDepth));

    logic in_fire, out_fire;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // RAM port steering: load writes in idle, moves read the giver's newest and write it to the taker.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {ld_rank, load_slot};
        ram_wdata = {in_data.task_b, in_data.task_a};
        ram_raddr = {hi_w, hi_slot};
        if (in_fire && in_data.req_type == REQ_LOAD && load_ok)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == ST_MOVE && moved_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = {lo_w, lo_slot};
            ram_wdata = ram_rdata;
        end
    end

    logic out_free;
    assign out_free = !out_valid_reg || out_fire;

    // The output register takes a new transfer in the emit and summary steps once it is free.
    logic out_load;
    assign out_load = ((state_reg == ST_EMIT) || (state_reg == ST_SUMM)) && out_free;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_fire && in_data.req_type == REQ_REBAL) state_next = ST_TRIM;
            ST_TRIM:
                if (idx_reg == n_eff - 1'b1) state_next = ST_SORT;
            ST_SORT:
                if (sorted_reg) state_next = ST_LO;
            ST_LO:
                if (lo_reg < hi_reg && total_reg[lo_w] >= CntW'(lo_share)) state_next = ST_LO;
                else state_next = ST_HI;
            ST_HI:
                if (lo_reg >= hi_reg) state_next = ST_SUMM;
                else if (total_reg[hi_w] <= CntW'(hi_share)) state_next = ST_HI;
                else state_next = ST_READ;
            ST_READ: state_next = ST_WAIT;
            ST_WAIT: state_next = ST_MOVE;
            ST_MOVE:
                if (moved_reg && lo_w == own_rank_reg && hi_w != own_rank_reg
                    && gains_reg < GainW'(GainCap)) state_next = ST_EMIT;
                else state_next = ST_LO;
            ST_EMIT:
                if (out_free) state_next = ST_LO;
            ST_SUMM:
                if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Held gain task for the emit step.
    logic [31:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            num_procs_reg <= 4'd8;
            own_rank_reg  <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            sum_reg       <= '0;
            raw_sum_reg   <= '0;
            lost_reg      <= '0;
            gains_reg     <= '0;
            moved_reg     <= 1'b0;
            sorted_reg    <= 1'b0;
            for (int i = 0; i < MaxProcs; i++)
            begin
                front_reg[i] <= '0;
                total_reg[i] <= '0;
                order_reg[i] <= RankW'(i);
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load) out_valid_reg <= 1'b1;
            else if (out_fire) out_valid_reg <= 1'b0;

            // Configuration writes.
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == REG_NUM_PROCS) num_procs_reg <= pwdata[3:0];
                else own_rank_reg <= pwdata[RankW-1:0];
            end

            unique case (state_reg)
                ST_IDLE:
                    if (in_fire)
                    begin
                        item_reg <= in_data;
                        unique case (in_data.req_type)
                            REQ_LOAD:
                                if ({1'b0, ld_rank} < n_eff)
                                begin
                                    if (load_ok) total_reg[ld_rank] <= total_reg[ld_rank] + 1'b1;
                                    else overflow_reg <= 1'b1;
                                end
                            REQ_CLEAR:
                            begin
                                overflow_reg <= 1'b0;
                                for (int i = 0; i < MaxProcs; i++)
                                begin
                                    front_reg[i] <= '0;
                                    total_reg[i] <= '0;
                                end
                            end
                            REQ_REBAL:
                            begin
                                idx_reg     <= '0;
                                sum_reg     <= '0;
                                raw_sum_reg <= '0;
                                lost_reg    <= '0;
                                gains_reg   <= '0;
                                for (int i = 0; i < MaxProcs; i++) order_reg[i] <= RankW'(i);
                            end
                            default: ;
                        endcase
                    end
                // Trim one list per cycle down to its reported count.
                ST_TRIM:
                begin : trim
                    logic [RankW-1:0] r;
                    logic [5:0]       c;
                    logic [CntW-1:0]  k;
                    r = idx_reg[RankW-1:0];
                    c = count_of(item_reg, r);
                    k = (CntW'(c) > total_reg[r]) ? total_reg[r] : CntW'(c);
                    front_reg[r] <= front_reg[r] + SlotW'(total_reg[r] - k);
                    total_reg[r] <= k;
                    sum_reg      <= sum_reg + SumW'(k);
                    raw_sum_reg  <= raw_sum_reg + SumW'(c);
                    sorted_reg   <= 1'b0;
                    idx_reg      <= (idx_reg == n_eff - 1'b1) ? '0 : idx_reg + 1'b1;
                end
                // Odd-even transposition sort, one phase per cycle.
                ST_SORT:
                begin : sort
                    logic swapped;
                    swapped = 1'b0;
                    for (int p = 0; p < MaxProcs - 1; p++)
                    begin
                        if ((p % 2) == int'(idx_reg[0]) && (p + 1) < int'(n_eff))
                        begin
                            if (total_reg[order_reg[p]] > total_reg[order_reg[p+1]] ||
                                (total_reg[order_reg[p]] == total_reg[order_reg[p+1]] &&
                                 order_reg[p] > order_reg[p+1]))
                            begin
                                order_reg[p]   <= order_reg[p+1];
                                order_reg[p+1] <= order_reg[p];
                                swapped = 1'b1;
                            end
                        end
                    end
                    idx_reg <= idx_reg + 1'b1;
                    lo_reg  <= '0;
                    hi_reg  <= n_eff - 1'b1;
                    if (idx_reg >= (RankW+1)'(MaxProcs - 1) ||
                        (!swapped && idx_reg[0] && idx_reg != '0))
                        sorted_reg <= 1'b1;
                end
                ST_LO:
                    if (lo_reg < hi_reg && total_reg[lo_w] >= CntW'(lo_share))
                        lo_reg <= lo_reg + 1'b1;
                ST_HI:
                    if (lo_reg < hi_reg && total_reg[hi_w] <= CntW'(hi_share))
                        hi_reg <= hi_reg - 1'b1;
                // Giver's newest is addressed; note the loss and whether it lands.
                ST_READ:
                begin
                    if (hi_w == own_rank_reg && {1'b0, own_rank_reg} < n_eff)
                        lost_reg <= lost_reg + 1'b1;
                    moved_reg <= (total_reg[lo_w] < CntW'(BucketDepth));
                end
                // Pop the giver's newest once its second read is issued.
                ST_WAIT:
                    total_reg[hi_w] <= total_reg[hi_w] - 1'b1;
                ST_MOVE:
                begin
                    gain_reg <= ram_rdata;
                    if (moved_reg) total_reg[lo_w] <= total_reg[lo_w] + 1'b1;
                end
                ST_EMIT:
                    if (out_free)
                    begin
                        out_reg.kind     <= KIND_GAIN;
                        out_reg.gained_a <= gain_reg[15:0];
                        out_reg.gained_b <= gain_reg[31:16];
                        out_reg.lost_count <= '0;
                        out_reg.pool_empty <= 1'b0;
                        out_reg.overflow   <= 1'b0;
                        out_reg.last       <= 1'b0;
                        gains_reg <= gains_reg + 1'b1;
                    end
                ST_SUMM:
                    if (out_free)
                    begin
                        out_reg.kind       <= KIND_SUM;
                        out_reg.gained_a   <= '0;
                        out_reg.gained_b   <= '0;
                        out_reg.lost_count <= 6'(lost_reg);
                        out_reg.pool_empty <= (raw_sum_reg == '0);
                        out_reg.overflow   <= overflow_reg;
                        out_reg.last       <= 1'b1;
                        overflow_reg       <= 1'b0;
                    end
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_NUM_PROCS) ? {28'd0, num_procs_reg}
                                                   : {29'd0, own_rank_reg};

    `TPR_ASSERT(a_onehot, $onehot(state_reg), "state not one-hot")
    `TPR_ASSERT_IMP(a_lohi, (state_reg == ST_READ), (lo_reg < hi_reg), "move with crossed pointers")
    `TPR_ASSERT_IMP(a_cap, (state_reg == ST_READ), (total_reg[hi_w] != '0), "pop from empty list")
    `TPR_ASSERT_IMP(a_sum_last, out_valid_reg, (out_reg.kind == out_reg.last), "kind and last differ")
endmodule
